>>> src/nbw_pkg.sv
// ----------------------------------------------------------------------------
// NAL bit writer package
// Shared widths, request codes, stream constants and the control struct that
// passes from the bit packer to the byte emitter.
// ----------------------------------------------------------------------------
package nbw_pkg;

	localparam int REQ_TYPE_W = 3;
	localparam int VALUE_W = 32;
	localparam int BIT_CNT_W = 6;
	localparam int SVAL_W = 16;
	localparam int BYTE_W = 8;
	localparam int PEND_W = 7;
	localparam int PCNT_W = 3;
	localparam int FIXED_MAX = 32;
	localparam int MAX_RESULTS = 8;
	localparam int CNT_W = 4;
	localparam int BYTES_W = 4;
	localparam int RAW_W = 3;
	localparam int GOLOMB_VALUE_BITS_DEF = 16;

	localparam logic [RAW_W-1:0] RAW_BYTES = 3'd4;
	localparam logic [BYTE_W-1:0] EMU_BYTE = 8'h03;
	localparam logic [BYTE_W-1:0] EMU_TRIGGER_MAX = 8'h03;
	localparam logic [BYTE_W-1:0] START_TAIL = 8'h01;
	localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;
	localparam logic [1:0] ZRUN_MAX = 2'd2;

	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_FIXED = 3'd0,
		REQ_UE    = 3'd1,
		REQ_SE    = 3'd2,
		REQ_TRAIL = 3'd3,
		REQ_ALIGN = 3'd4,
		REQ_START = 3'd5
	} nbw_req_t;

	typedef struct packed {
		logic err;
		logic start;
		logic [BYTES_W-1:0] data_cnt;
	} nbw_ctl_t;

	function automatic int code_w(int gvb);
		return (2 * gvb - 1 > FIXED_MAX) ? 2 * gvb - 1 : FIXED_MAX;
	endfunction

	function automatic int full_w(int gvb);
		return code_w(gvb) + PEND_W;
	endfunction

	function automatic int buf_w(int gvb);
		return (full_w(gvb) / BYTE_W) * BYTE_W;
	endfunction

endpackage

>>> src/nbw_if.sv
// ----------------------------------------------------------------------------
// NAL bit writer channels
// Request and result channels with valid/ready handshakes; a beat moves when
// valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface nbw_req_if;
	import nbw_pkg::*;

	logic valid;
	logic ready;
	logic [REQ_TYPE_W-1:0] req_type;
	logic [VALUE_W-1:0] value;
	logic [BIT_CNT_W-1:0] bit_count;
	logic signed [SVAL_W-1:0] signed_value;

	modport source (output valid, req_type, value, bit_count, signed_value, input ready);
	modport sink (input valid, req_type, value, bit_count, signed_value, output ready);
endinterface

interface nbw_res_if;
	import nbw_pkg::*;

	logic valid;
	logic ready;
	logic [BYTE_W-1:0] out_byte;
	logic emulation_byte;
	logic error;
	logic last;

	modport source (output valid, out_byte, emulation_byte, error, last, input ready);
	modport sink (input valid, out_byte, emulation_byte, error, last, output ready);
endinterface

>>> src/nbw_pack.sv
// ----------------------------------------------------------------------------
// NAL bit writer packer
// Builds the code bits of one request, joins them to the pending partial
// byte and splits the result into whole bytes and a new partial byte.
// ----------------------------------------------------------------------------
module nbw_pack #(
	parameter int GOLOMB_VALUE_BITS = nbw_pkg::GOLOMB_VALUE_BITS_DEF
) (
	input  logic [nbw_pkg::REQ_TYPE_W-1:0] req_type,
	input  logic [nbw_pkg::VALUE_W-1:0] value,
	input  logic [nbw_pkg::BIT_CNT_W-1:0] bit_count,
	input  logic signed [nbw_pkg::SVAL_W-1:0] signed_value,
	input  logic [nbw_pkg::PEND_W-1:0] pend_bits,
	input  logic [nbw_pkg::PCNT_W-1:0] pend_cnt,
	output nbw_pkg::nbw_ctl_t ctl,
	output logic [nbw_pkg::buf_w(GOLOMB_VALUE_BITS)-1:0] data_bits,
	output logic [nbw_pkg::PEND_W-1:0] pend_bits_nxt,
	output logic [nbw_pkg::PCNT_W-1:0] pend_cnt_nxt
);
	import nbw_pkg::*;

	localparam int GVB = GOLOMB_VALUE_BITS;
	localparam int CODE_W = code_w(GVB);
	localparam int FULL_W = full_w(GVB);
	localparam int BUF_W = buf_w(GVB);
	localparam int LEN_W = $clog2(CODE_W + 1);
	localparam int TOT_W = $clog2(FULL_W + 1);
	localparam int GL_W = $clog2(GVB + 1);
	localparam int MAP_W = SVAL_W + 1;
	localparam logic [VALUE_W-1:0] UE_LIMIT = VALUE_W'((64'd1 << GVB) - 64'd2);

	logic [BIT_CNT_W-1:0] nb_clip;
	logic [VALUE_W-1:0] fix_mask;
	logic se_pos;
	logic signed [SVAL_W+1:0] s2;
	logic [MAP_W-1:0] se_map;
	logic [VALUE_W-1:0] ue_in;
	logic ue_err;
	logic [GVB-1:0] ue_v;
	logic [GL_W-1:0] ue_l;
	logic [3:0] align_len;
	logic [3:0] trail_len;
	logic [CODE_W-1:0] code;
	logic [LEN_W-1:0] code_len;
	logic err;
	logic start;
	logic [FULL_W-1:0] full;
	logic [FULL_W-1:0] aligned;
	logic [TOT_W-1:0] total;
	logic [PCNT_W-1:0] rem;

	assign nb_clip = (bit_count > BIT_CNT_W'(FIXED_MAX)) ? BIT_CNT_W'(FIXED_MAX) : bit_count;
	assign fix_mask = (nb_clip == BIT_CNT_W'(FIXED_MAX)) ? '1 :
		((VALUE_W'(1) << nb_clip) - VALUE_W'(1));

	// Signed mapping: positive s goes to 2s-1, zero and negative s to -2s.
	assign se_pos = !signed_value[SVAL_W-1] && (signed_value != '0);
	assign s2 = {signed_value[SVAL_W-1], signed_value, 1'b0};
	assign se_map = se_pos ? MAP_W'(s2 - 1) : MAP_W'(-s2);

	assign ue_in = (req_type == REQ_UE) ? value : VALUE_W'(se_map);
	assign ue_err = ue_in > UE_LIMIT;
	assign ue_v = ue_in[GVB-1:0] + GVB'(1);

	always_comb begin
		ue_l = '0;
		for (int i = 0; i < GVB; i++) begin
			if (ue_v[i]) begin
				ue_l = GL_W'(i + 1);
			end
		end
	end

	assign align_len = (pend_cnt == '0) ? 4'd0 : 4'd8 - {1'b0, pend_cnt};
	assign trail_len = 4'd8 - {1'b0, pend_cnt};

	always_comb begin
		code = '0;
		code_len = '0;
		err = 1'b0;
		start = 1'b0;
		case (nbw_req_t'(req_type)) inside
			REQ_FIXED: begin
				code = CODE_W'(value & fix_mask);
				code_len = LEN_W'(nb_clip);
			end
			REQ_UE, REQ_SE: begin
				if (ue_err) begin
					err = 1'b1;
				end else begin
					code = CODE_W'(ue_v);
					code_len = LEN_W'({ue_l, 1'b0}) - LEN_W'(1);
				end
			end
			REQ_TRAIL: begin
				code = CODE_W'(1) << (3'd7 - pend_cnt);
				code_len = LEN_W'(trail_len);
			end
			REQ_ALIGN: begin
				code_len = LEN_W'(align_len);
			end
			REQ_START: begin
				code_len = LEN_W'(align_len);
				start = 1'b1;
			end
			default: begin
				code_len = '0;
			end
		endcase
	end

	assign full = (FULL_W'(pend_bits) << code_len) | FULL_W'(code);
	assign total = TOT_W'(pend_cnt) + TOT_W'(code_len);
	assign rem = total[PCNT_W-1:0];
	assign aligned = full << (TOT_W'(FULL_W) - total);

	assign data_bits = aligned[FULL_W-1 -: BUF_W];
	assign pend_bits_nxt = PEND_W'(full) & ((PEND_W'(1) << rem) - PEND_W'(1));
	assign pend_cnt_nxt = rem;

	assign ctl.err = err;
	assign ctl.start = start;
	assign ctl.data_cnt = BYTES_W'(total[TOT_W-1:PCNT_W]);

endmodule

>>> src/nbw_emit.sv
// ----------------------------------------------------------------------------
// NAL bit writer byte emitter
// Sends the bytes of one request one beat per cycle unless the output stalls,
// inserts the 0x03 prevention byte after two zero bytes before a byte of 0x03
// or less, appends start codes and holds the result in an output register.
// ----------------------------------------------------------------------------
module nbw_emit #(
	parameter int GOLOMB_VALUE_BITS = nbw_pkg::GOLOMB_VALUE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  nbw_pkg::nbw_ctl_t ctl,
	input  logic [nbw_pkg::buf_w(GOLOMB_VALUE_BITS)-1:0] data_bits,
	output logic free,
	nbw_res_if.source res
);
	import nbw_pkg::*;

	localparam int BUF_W = buf_w(GOLOMB_VALUE_BITS);

	logic [BUF_W-1:0] data_q;
	logic [BYTES_W-1:0] data_left_q;
	logic [RAW_W-1:0] raw_left_q;
	logic err_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0] zrun_q;

	logic out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic out_emu_q;
	logic out_err_q;
	logic out_last_q;

	logic busy;
	logic capped;
	logic out_free;
	logic step;
	logic push;
	logic [BYTE_W-1:0] cur;
	logic need_emu;

	logic [BUF_W-1:0] data_n;
	logic [BYTES_W-1:0] data_left_n;
	logic [RAW_W-1:0] raw_left_n;
	logic err_n;
	logic [1:0] zrun_n;
	logic done_n;
	logic [BYTE_W-1:0] r_byte;
	logic r_emu;
	logic r_err;
	logic r_last;

	assign busy = err_q || (data_left_q != '0) || (raw_left_q != '0);
	assign capped = cnt_q == CNT_W'(MAX_RESULTS);
	assign out_free = !out_valid_q || res.ready;
	assign step = busy && (capped || out_free);
	assign push = step && !capped;
	assign cur = data_q[BUF_W-1 -: BYTE_W];
	assign need_emu = (zrun_q == ZRUN_MAX) && (cur <= EMU_TRIGGER_MAX);

	always_comb begin
		data_n = data_q;
		data_left_n = data_left_q;
		raw_left_n = raw_left_q;
		err_n = err_q;
		zrun_n = zrun_q;
		r_byte = ZERO_BYTE;
		r_emu = 1'b0;
		r_err = 1'b0;
		if (err_q) begin
			r_err = 1'b1;
			err_n = 1'b0;
		end else if (data_left_q != '0) begin
			if (need_emu) begin
				r_byte = EMU_BYTE;
				r_emu = 1'b1;
				zrun_n = '0;
			end else begin
				r_byte = cur;
				data_n = data_q << BYTE_W;
				data_left_n = data_left_q - BYTES_W'(1);
				if (cur == ZERO_BYTE) begin
					zrun_n = (zrun_q == ZRUN_MAX) ? ZRUN_MAX : zrun_q + 2'd1;
				end else begin
					zrun_n = '0;
				end
			end
		end else begin
			r_byte = (raw_left_q == RAW_W'(1)) ? START_TAIL : ZERO_BYTE;
			raw_left_n = raw_left_q - RAW_W'(1);
			zrun_n = '0;
		end
		done_n = !err_n && (data_left_n == '0) && (raw_left_n == '0);
		r_last = done_n || (cnt_q == CNT_W'(MAX_RESULTS - 1));
	end

	assign free = !busy || (step && done_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_left_q <= '0;
			raw_left_q <= '0;
			err_q <= 1'b0;
			cnt_q <= '0;
			zrun_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				zrun_q <= zrun_n;
			end
			if (load) begin
				data_left_q <= ctl.data_cnt;
				raw_left_q <= ctl.start ? RAW_BYTES : '0;
				err_q <= ctl.err;
				cnt_q <= '0;
			end else if (step) begin
				data_left_q <= data_left_n;
				raw_left_q <= raw_left_n;
				err_q <= err_n;
				if (push) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data_bits;
		end else if (step) begin
			data_q <= data_n;
		end
		if (push) begin
			out_byte_q <= r_byte;
			out_emu_q <= r_emu;
			out_err_q <= r_err;
			out_last_q <= r_last;
		end
	end

	assign res.valid = out_valid_q;
	assign res.out_byte = out_byte_q;
	assign res.emulation_byte = out_emu_q;
	assign res.error = out_err_q;
	assign res.last = out_last_q;

endmodule

>>> src/nal_bit_writer_exp_golomb_core.sv
// ----------------------------------------------------------------------------
// NAL bit writer with Exp-Golomb coding and emulation prevention
// A request passes the stage-1 register and the emitter state into the output
// register. Throughput: one result beat per cycle while the result side is
// ready; the emitter takes the next request as it sends the last result of
// the current one, so single-byte requests stream at one per cycle.
// Reset clears the pending partial byte, the zero-byte run and all valid flags.
// ----------------------------------------------------------------------------
module nal_bit_writer_exp_golomb_core #(
	parameter int GOLOMB_VALUE_BITS = nbw_pkg::GOLOMB_VALUE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	nbw_req_if.sink req,
	nbw_res_if.source res
);
	import nbw_pkg::*;

	localparam int BUF_W = buf_w(GOLOMB_VALUE_BITS);

	logic valid_s1;
	logic [REQ_TYPE_W-1:0] req_type_s1;
	logic [VALUE_W-1:0] value_s1;
	logic [BIT_CNT_W-1:0] bit_count_s1;
	logic signed [SVAL_W-1:0] sval_s1;

	logic [PEND_W-1:0] pend_bits_q;
	logic [PCNT_W-1:0] pend_cnt_q;

	nbw_ctl_t ctl;
	logic [BUF_W-1:0] data_bits;
	logic [PEND_W-1:0] pend_bits_nxt;
	logic [PCNT_W-1:0] pend_cnt_nxt;
	logic em_free;
	logic load;
	logic accept;

	assign load = valid_s1 && em_free;
	assign req.ready = !valid_s1 || load;
	assign accept = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pend_bits_q <= '0;
			pend_cnt_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (load) begin
				valid_s1 <= 1'b0;
			end
			if (load) begin
				pend_bits_q <= pend_bits_nxt;
				pend_cnt_q <= pend_cnt_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1 <= req.req_type;
			value_s1 <= req.value;
			bit_count_s1 <= req.bit_count;
			sval_s1 <= req.signed_value;
		end
	end

	nbw_pack #(
		.GOLOMB_VALUE_BITS(GOLOMB_VALUE_BITS)
	) u_pack (
		.req_type(req_type_s1),
		.value(value_s1),
		.bit_count(bit_count_s1),
		.signed_value(sval_s1),
		.pend_bits(pend_bits_q),
		.pend_cnt(pend_cnt_q),
		.ctl(ctl),
		.data_bits(data_bits),
		.pend_bits_nxt(pend_bits_nxt),
		.pend_cnt_nxt(pend_cnt_nxt)
	);

	nbw_emit #(
		.GOLOMB_VALUE_BITS(GOLOMB_VALUE_BITS)
	) u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.load(load),
		.ctl(ctl),
		.data_bits(data_bits),
		.free(em_free),
		.res(res)
	);

	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.error |-> res.last && !res.emulation_byte && res.out_byte == ZERO_BYTE)
		else $error("error beat carries stream data");

	a_emu_beat: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.emulation_byte |-> res.out_byte == EMU_BYTE && !res.error)
		else $error("prevention beat has wrong content");

	a_pend_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_bits_q >> pend_cnt_q) == PEND_W'(0))
		else $error("pending bits above the pending count are not zero");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !load |=> valid_s1 && $stable(req_type_s1) && $stable(value_s1))
		else $error("staged request lost before it reached the emitter");

endmodule

>>> sim/tb_nal_bit_writer_exp_golomb_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the NAL bit writer core
// Drives request beats in random bursts and checks every result beat against
// a local model of the bit packer. The model covers the Exp-Golomb codes, the
// start codes and the insertion of emulation prevention bytes. Directed corner
// cases run first, followed by random requests and slice-like request runs.
// The result side stalls on patterns of its own, including one long hold-off.
// ----------------------------------------------------------------------------
module tb_nal_bit_writer_exp_golomb_core;
	import nbw_pkg::*;

	localparam int CLK_HALF = 5;
	localparam int RESET_CYCLES = 2;
	localparam int RANDOM_ITEMS = 330;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER_BEATS = 120;
	localparam int DRAIN_CYCLES = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int GOLOMB_BITS = GOLOMB_VALUE_BITS_DEF;
	localparam logic [VALUE_W-1:0] GOLOMB_LIMIT = (32'd1 << GOLOMB_BITS) - 32'd2;
	localparam logic [REQ_TYPE_W-1:0] REQ_RSVD6 = 3'd6;
	localparam logic [REQ_TYPE_W-1:0] REQ_RSVD7 = 3'd7;

	typedef struct {
		logic [REQ_TYPE_W-1:0] req_type;
		logic [VALUE_W-1:0] value;
		logic [BIT_CNT_W-1:0] bit_count;
		logic signed [SVAL_W-1:0] signed_value;
	} req_item_t;

	typedef struct {
		logic [BYTE_W-1:0] out_byte;
		logic emulation_byte;
		logic error;
		logic last;
	} res_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	nbw_req_if req_ch();
	nbw_res_if res_ch();

	nal_bit_writer_exp_golomb_core #(
		.GOLOMB_VALUE_BITS(GOLOMB_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch)
	);

	always #CLK_HALF clk = ~clk;

	req_item_t req_backlog[$];
	res_beat_t expected_bytes[$];
	res_beat_t req_beats[$];
	req_item_t on_bus;
	res_beat_t want;

	logic [BYTE_W-1:0] wr_acc;
	int unsigned wr_cnt;
	int unsigned wr_zeros;

	int fail_count = 0;
	int reqs_accepted = 0;
	int result_beats = 0;
	int emu_seen = 0;
	int errors_seen = 0;
	int hold_seen = 0;
	int idle_cycles = 0;
	int burst_left;
	int gap_left;
	int rx_cycle;
	int rx_mode;
	int rx_beats;
	int hold_left;
	bit hold_done;

	// Bit packer model.
	function automatic void add_stream_beat(logic [BYTE_W-1:0] b, logic emu, logic err);
		res_beat_t beat;
		beat.out_byte = b;
		beat.emulation_byte = emu;
		beat.error = err;
		beat.last = 1'b0;
		req_beats = {req_beats, beat};
	endfunction

	function automatic void stream_data_byte(logic [BYTE_W-1:0] b);
		if (wr_zeros >= ZRUN_MAX && b <= EMU_TRIGGER_MAX) begin
			add_stream_beat(EMU_BYTE, 1'b1, 1'b0);
			wr_zeros = 0;
		end
		add_stream_beat(b, 1'b0, 1'b0);
		if (b == ZERO_BYTE)
			wr_zeros = (wr_zeros >= ZRUN_MAX) ? ZRUN_MAX : wr_zeros + 1;
		else
			wr_zeros = 0;
	endfunction

	function automatic void stream_put_bits(logic [VALUE_W-1:0] bits, int n);
		for (int i = n - 1; i >= 0; i--) begin
			wr_acc = {wr_acc[BYTE_W-2:0], bits[i]};
			wr_cnt++;
			if (wr_cnt == BYTE_W) begin
				stream_data_byte(wr_acc);
				wr_acc = '0;
				wr_cnt = 0;
			end
		end
	endfunction

	function automatic void stream_align();
		if (wr_cnt > 0)
			stream_put_bits('0, BYTE_W - wr_cnt);
	endfunction

	function automatic bit stream_put_golomb(logic [VALUE_W-1:0] code_val);
		logic [VALUE_W-1:0] v;
		int len;
		if (code_val > GOLOMB_LIMIT)
			return 1'b0;
		v = code_val + 32'd1;
		len = 0;
		while (len < VALUE_W && (v >> len) != 0)
			len++;
		stream_put_bits('0, len - 1);
		stream_put_bits(v, len);
		return 1'b1;
	endfunction

	function automatic void encode_request(req_item_t r);
		int nb;
		int s;
		logic [VALUE_W-1:0] val;
		logic [VALUE_W-1:0] mapped;
		bit ok;
		req_beats.delete();
		ok = 1'b1;
		case (r.req_type)
			REQ_FIXED: begin
				nb = (r.bit_count > FIXED_MAX) ? FIXED_MAX : int'(r.bit_count);
				val = r.value;
				if (nb < FIXED_MAX)
					val &= (32'd1 << nb) - 32'd1;
				stream_put_bits(val, nb);
			end
			REQ_UE: begin
				ok = stream_put_golomb(r.value);
			end
			REQ_SE: begin
				s = r.signed_value;
				mapped = (s > 0) ? 2 * s - 1 : -2 * s;
				ok = stream_put_golomb(mapped);
			end
			REQ_TRAIL: begin
				stream_put_bits(32'd1, 1);
				stream_align();
			end
			REQ_ALIGN: begin
				stream_align();
			end
			REQ_START: begin
				stream_align();
				for (int i = 0; i < RAW_BYTES - 1; i++)
					add_stream_beat(ZERO_BYTE, 1'b0, 1'b0);
				add_stream_beat(START_TAIL, 1'b0, 1'b0);
				wr_zeros = 0;
			end
			default: begin
			end
		endcase
		if (!ok) begin
			req_beats.delete();
			add_stream_beat(ZERO_BYTE, 1'b0, 1'b1);
		end
		while (req_beats.size() > MAX_RESULTS)
			void'(req_beats.pop_back());
		if (req_beats.size() > 0)
			req_beats[req_beats.size() - 1].last = 1'b1;
		expected_bytes = {expected_bytes, req_beats};
	endfunction

	// Stimulus.
	function automatic void queue_req(logic [REQ_TYPE_W-1:0] kind, logic [VALUE_W-1:0] val,
			logic [BIT_CNT_W-1:0] nb, logic signed [SVAL_W-1:0] sval);
		req_item_t r;
		r.req_type = kind;
		r.value = val;
		r.bit_count = nb;
		r.signed_value = sval;
		req_backlog = {req_backlog, r};
	endfunction

	function automatic void queue_code_item();
		int pick;
		logic [VALUE_W-1:0] v;
		logic [SVAL_W-1:0] sv;
		pick = $urandom_range(0, 99);
		v = $urandom;
		sv = SVAL_W'($urandom);
		if (pick < 25)
			queue_req(REQ_FIXED, v, BIT_CNT_W'($urandom_range(0, FIXED_MAX)), sv);
		else if (pick < 30)
			queue_req(REQ_FIXED, v, BIT_CNT_W'($urandom_range(FIXED_MAX + 1, 63)), sv);
		else if (pick < 42)
			queue_req(REQ_FIXED, $urandom_range(0, 3),
				BIT_CNT_W'($urandom_range(8, FIXED_MAX)), sv);
		else if (pick < 55)
			queue_req(REQ_UE, $urandom_range(0, 62), BIT_CNT_W'($urandom_range(0, 63)), sv);
		else if (pick < 62)
			queue_req(REQ_UE, $urandom_range(0, 65534), BIT_CNT_W'($urandom_range(0, 63)), sv);
		else if (pick < 65)
			queue_req(REQ_UE, v | 32'h0001_0000, BIT_CNT_W'($urandom_range(0, 63)), sv);
		else if (pick < 78)
			queue_req(REQ_SE, v, BIT_CNT_W'($urandom_range(0, 63)),
				SVAL_W'(int'($urandom_range(0, 62)) - 31));
		else if (pick < 86)
			queue_req(REQ_SE, v, BIT_CNT_W'($urandom_range(0, 63)), sv);
		else if (pick < 91)
			queue_req(REQ_TRAIL, v, BIT_CNT_W'($urandom_range(0, 63)), sv);
		else if (pick < 96)
			queue_req(REQ_ALIGN, v, BIT_CNT_W'($urandom_range(0, 63)), sv);
		else
			queue_req(REQ_START, v, BIT_CNT_W'($urandom_range(0, 63)), sv);
	endfunction

	function automatic int queue_random_req();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			queue_req(($urandom_range(0, 1) != 0) ? REQ_RSVD6 : REQ_RSVD7, $urandom,
				BIT_CNT_W'($urandom_range(0, 63)), SVAL_W'($urandom));
			return 0;
		end
		if (pick < 20) begin
			// A slice-like run: start code, header byte, a few codes and trailing bits.
			n = $urandom_range(2, 6);
			queue_req(REQ_START, $urandom, BIT_CNT_W'($urandom_range(0, 63)),
				SVAL_W'($urandom));
			queue_req(REQ_FIXED, $urandom_range(0, 255), BIT_CNT_W'(BYTE_W),
				SVAL_W'($urandom));
			for (int i = 0; i < n; i++)
				queue_code_item();
			queue_req(REQ_TRAIL, $urandom, BIT_CNT_W'($urandom_range(0, 63)),
				SVAL_W'($urandom));
			return n + 3;
		end
		queue_code_item();
		return 1;
	endfunction

	// Request driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.req_type <= '0;
			req_ch.value <= '0;
			req_ch.bit_count <= '0;
			req_ch.signed_value <= '0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				encode_request(on_bus);
				reqs_accepted++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left > 0 || req_backlog.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					req_ch.valid <= 1'b0;
				end else begin
					on_bus = req_backlog.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.req_type <= on_bus.req_type;
					req_ch.value <= on_bus.value;
					req_ch.bit_count <= on_bus.bit_count;
					req_ch.signed_value <= on_bus.signed_value;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
							: $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	// Result receiver with its own stall pattern and one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			rx_cycle = 0;
			rx_mode = 0;
			rx_beats = 0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready)
				rx_beats++;
			rx_cycle++;
			if (rx_cycle % 64 == 0)
				rx_mode = $urandom_range(0, 3);
			if (!hold_done && rx_beats >= HOLD_AFTER_BEATS) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				hold_seen++;
				res_ch.ready <= 1'b0;
			end else begin
				case (rx_mode)
					0: res_ch.ready <= 1'b1;
					1: res_ch.ready <= 1'($urandom_range(0, 1));
					2: res_ch.ready <= ($urandom_range(0, 7) != 0);
					default: res_ch.ready <= (rx_cycle % 3 != 0);
				endcase
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			result_beats++;
			if (res_ch.emulation_byte)
				emu_seen++;
			if (res_ch.error)
				errors_seen++;
			if (expected_bytes.size() == 0) begin
				fail_count++;
				$error("Result beat with nothing expected: out_byte 0x%02h", res_ch.out_byte);
			end else begin
				want = expected_bytes.pop_front();
				if (res_ch.out_byte !== want.out_byte) begin
					fail_count++;
					$error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte,
						res_ch.out_byte);
				end
				if (res_ch.emulation_byte !== want.emulation_byte) begin
					fail_count++;
					$error("emulation_byte: expected %0b, got %0b", want.emulation_byte,
						res_ch.emulation_byte);
				end
				if (res_ch.error !== want.error) begin
					fail_count++;
					$error("error: expected %0b, got %0b", want.error, res_ch.error);
				end
				if (res_ch.last !== want.last) begin
					fail_count++;
					$error("last: expected %0b, got %0b", want.last, res_ch.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired with %0d result beats still expected.",
					expected_bytes.size());
				$display("RESULT: ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int random_count;
		arst_n <= 1'b0;
		wr_acc = '0;
		wr_cnt = 0;
		wr_zeros = 0;

		queue_req(REQ_FIXED, 32'hFFFF_FFFF, 6'd0, 16'sd0);
		queue_req(REQ_FIXED, 32'hFFFF_FFFF, 6'd32, 16'sd0);
		queue_req(REQ_FIXED, 32'hA5A5_5A5A, 6'd63, 16'sd0);
		queue_req(REQ_FIXED, 32'd5, 6'd3, 16'sd0);
		queue_req(REQ_TRAIL, 32'd0, 6'd0, 16'sd0);
		queue_req(REQ_ALIGN, 32'd0, 6'd0, 16'sd0);
		queue_req(REQ_UE, 32'd0, 6'd0, 16'sd0);
		queue_req(REQ_UE, 32'd65534, 6'd0, 16'sd0);
		queue_req(REQ_UE, 32'd65535, 6'd0, 16'sd0);
		queue_req(REQ_UE, 32'hFFFF_FFFF, 6'd0, 16'sd0);
		queue_req(REQ_SE, 32'd0, 6'd0, 16'sd0);
		queue_req(REQ_SE, 32'd0, 6'd0, 16'sd32767);
		queue_req(REQ_SE, 32'd0, 6'd0, -16'sd32767);
		queue_req(REQ_SE, 32'd0, 6'd0, 16'sh8000);
		queue_req(REQ_SE, 32'd0, 6'd0, 16'sd1);
		queue_req(REQ_ALIGN, 32'd0, 6'd0, 16'sd0);
		queue_req(REQ_FIXED, 32'd0, 6'd32, 16'sd0);
		queue_req(REQ_FIXED, 32'd3, 6'd8, 16'sd0);
		queue_req(REQ_START, 32'd0, 6'd0, 16'sd0);
		queue_req(REQ_FIXED, 32'd0, 6'd16, 16'sd0);
		queue_req(REQ_FIXED, 32'd4, 6'd8, 16'sd0);
		queue_req(REQ_FIXED, 32'd1, 6'd5, 16'sd0);
		queue_req(REQ_START, 32'd0, 6'd0, 16'sd0);
		queue_req(REQ_RSVD6, 32'hFFFF_FFFF, 6'd63, -16'sd1);
		queue_req(REQ_RSVD7, 32'd0, 6'd8, 16'sd0);
		queue_req(REQ_TRAIL, 32'd0, 6'd0, 16'sd0);

		random_count = 0;
		while (random_count < RANDOM_ITEMS)
			random_count += queue_random_req();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (req_backlog.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d requests and %0d result beats, with %0d prevention bytes",
			reqs_accepted, result_beats, emu_seen);
		$display("and %0d range errors; the receiver held off for %0d cycles under load.",
			errors_seen, hold_seen);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> sim.f
src/nbw_pkg.sv
src/nbw_if.sv
src/nbw_pack.sv
src/nbw_emit.sv
src/nal_bit_writer_exp_golomb_core.sv
sim/tb_nal_bit_writer_exp_golomb_core.sv
